FILE: rtl/rti_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rti_pkg
// widths, register codes and helpers for the ray/triangle intersection block
// ----------------------------------------------------------------------------
package rti_pkg;

   localparam int CB = 20;            // coordinate bits
   localparam int FB = 20;            // coordinate field bits on the stream
   localparam int CW = CB + 1;        // edge and offset vector bits
   localparam int PW = 2 * CW;        // minor product bits
   localparam int MW = PW + 1;        // minor bits
   localparam int XW = CW + MW;       // cofactor product bits
   localparam int DW = XW + 4;        // determinant bits
   localparam int QB = 33;            // quotient bits kept before saturation
   localparam int FRAC = 16;          // fraction bits of the distance
   localparam int VW = 3 * CB;        // packed vertex bits in use
   localparam int RW = 60;            // vertex register bits
   localparam int AW = 5;             // csr address bits
   localparam int NDET = 4;

   typedef enum logic [1:0] {
      REG_VERTEX_A = 2'd0,
      REG_VERTEX_B = 2'd1,
      REG_VERTEX_C = 2'd2,
      REG_NONE     = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic hit;
      logic tneg;
      logic ovf;
   } div_ctrl_type;

   function automatic logic signed [CB-1:0] coord_of(input logic [FB-1:0] f);
      logic [CB+FB-1:0] t;
      t = {{CB{1'b0}}, f};
      return t[CB-1:0];
   endfunction

endpackage
`default_nettype wire

FILE: rtl/ray_triangle_intersect.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ray_triangle_intersect
// Ray against one stored triangle by Cramer's rule, exact integer tests.
// Takes one ray word per cycle and returns one result word per ray, in order.
// Six stages form the four determinants and the hit tests, one stage loads
// the divider, 33 stages of a restoring divider each produce one bit of t,
// and one stage saturates. The divider chain sets the depth. A stall on the
// result side holds the whole pipeline. Vertices must be written over the csr
// port only while no ray is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module ray_triangle_intersect (
   input  wire logic                       clock,
   input  wire logic                       reset,
   // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z (20 bits each)
   input  wire logic [6*rti_pkg::FB-1:0]   req_tdata,
   input  wire logic                       req_tvalid,
   output logic                            req_tready,
   // hit, distance (32 bits), zero pad
   output logic [39:0]                     rsp_tdata,
   output logic                            rsp_tvalid,
   input  wire logic                       rsp_tready,
   input  wire logic                       csr_psel,
   input  wire logic                       csr_penable,
   input  wire logic                       csr_pwrite,
   input  wire logic [rti_pkg::AW-1:0]     csr_paddr,
   input  wire logic [63:0]                csr_pwdata,
   output logic [63:0]                     csr_prdata,
   output logic                            csr_pready
);
   import rti_pkg::*;

   logic [RW-1:0] vert_ff [3];
   reg_index_type widx;
   logic          adv;

   // csr
   assign csr_pready = 1'b1;
   assign widx = reg_index_type'(csr_paddr[AW-1:3]);

   always_ff @(posedge clock) begin
      if (reset) begin
         vert_ff[0] <= '0;
         vert_ff[1] <= '0;
         vert_ff[2] <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
         case (widx)
            REG_VERTEX_A: vert_ff[0] <= csr_pwdata[RW-1:0];
            REG_VERTEX_B: vert_ff[1] <= csr_pwdata[RW-1:0];
            REG_VERTEX_C: vert_ff[2] <= csr_pwdata[RW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (widx)
         REG_VERTEX_A: csr_prdata = {{(64-RW){1'b0}}, vert_ff[0]};
         REG_VERTEX_B: csr_prdata = {{(64-RW){1'b0}}, vert_ff[1]};
         REG_VERTEX_C: csr_prdata = {{(64-RW){1'b0}}, vert_ff[2]};
         default:      csr_prdata = '0;
      endcase
   end

   // whole pipeline moves unless the output word is stuck
   logic out_v_ff;
   assign adv        = !out_v_ff || rsp_tready;
   assign req_tready = adv;

   // stage 1: edge, offset and direction vectors
   logic signed [CB-1:0] va [3], vb [3], vc [3], org [3], dir [3];
   logic signed [CW-1:0] e1_ff [3], e2_ff [3], s_ff [3], d_ff [3];
   logic                 v1_ff;

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         va[a]  = vert_ff[0][a*CB +: CB];
         vb[a]  = vert_ff[1][a*CB +: CB];
         vc[a]  = vert_ff[2][a*CB +: CB];
         org[a] = coord_of(req_tdata[a*FB +: FB]);
         dir[a] = coord_of(req_tdata[(a+3)*FB +: FB]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int a = 0; a < 3; a++) begin
            e1_ff[a] <= CW'(va[a]) - CW'(vb[a]);
            e2_ff[a] <= CW'(va[a]) - CW'(vc[a]);
            s_ff[a]  <= CW'(va[a]) - CW'(org[a]);
            d_ff[a]  <= CW'(dir[a]);
         end
      end
   end

   // determinant columns: den, db, dg, dt
   logic signed [CW-1:0] col [NDET][3][3];
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         col[0][0][a] = e1_ff[a]; col[0][1][a] = e2_ff[a]; col[0][2][a] = d_ff[a];
         col[1][0][a] = s_ff[a];  col[1][1][a] = e2_ff[a]; col[1][2][a] = d_ff[a];
         col[2][0][a] = e1_ff[a]; col[2][1][a] = s_ff[a];  col[2][2][a] = d_ff[a];
         col[3][0][a] = e1_ff[a]; col[3][1][a] = e2_ff[a]; col[3][2][a] = s_ff[a];
      end
   end

   // stage 2: minor products; stage 3: minors; stage 4: cofactor products
   logic signed [PW-1:0] pp_ff [NDET][6];
   logic signed [CW-1:0] top2_ff [NDET][3], top3_ff [NDET][3];
   logic signed [MW-1:0] mn_ff [NDET][3];
   logic signed [XW-1:0] xp_ff [NDET][3];
   logic signed [DW-1:0] det_ff [NDET];
   logic                 v2_ff, v3_ff, v4_ff, v5_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < NDET; k++) begin
            pp_ff[k][0] <= col[k][1][1] * col[k][2][2];
            pp_ff[k][1] <= col[k][2][1] * col[k][1][2];
            pp_ff[k][2] <= col[k][0][1] * col[k][2][2];
            pp_ff[k][3] <= col[k][2][1] * col[k][0][2];
            pp_ff[k][4] <= col[k][0][1] * col[k][1][2];
            pp_ff[k][5] <= col[k][1][1] * col[k][0][2];
            for (int c = 0; c < 3; c++) begin
               top2_ff[k][c] <= col[k][c][0];
               top3_ff[k][c] <= top2_ff[k][c];
               mn_ff[k][c]   <= MW'(pp_ff[k][2*c]) - MW'(pp_ff[k][2*c+1]);
               xp_ff[k][c]   <= top3_ff[k][c] * mn_ff[k][c];
            end
            det_ff[k] <= DW'(xp_ff[k][0]) - DW'(xp_ff[k][1]) + DW'(xp_ff[k][2]);
         end
      end
   end

   // stage 6: hit tests and magnitudes
   logic             bok, gok, sok, dneg, den_zero;
   logic signed [DW-1:0] diff;
   logic             hit6_ff, tneg6_ff, v6_ff;
   logic [DW-1:0]    n6_ff, m6_ff;

   always_comb begin
      dneg     = det_ff[0][DW-1];
      den_zero = (det_ff[0] == '0);
      bok      = (det_ff[1] == '0) || (det_ff[1][DW-1] == dneg);
      gok      = (det_ff[2] == '0) || (det_ff[2][DW-1] == dneg);
      diff     = det_ff[1] + det_ff[2] - det_ff[0];
      sok      = dneg ? !diff[DW-1] : (diff[DW-1] || diff == '0);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         hit6_ff  <= !den_zero && bok && gok && sok;
         tneg6_ff <= det_ff[3][DW-1] != dneg;
         n6_ff    <= det_ff[3][DW-1] ? DW'(-det_ff[3]) : DW'(det_ff[3]);
         m6_ff    <= dneg ? DW'(-det_ff[0]) : DW'(det_ff[0]);
      end
   end

   // divider: one quotient bit per stage
   logic [DW-1:0]  rem_ff  [0:QB];
   logic [QB-1:0]  nlo_ff  [0:QB];
   logic [QB-1:0]  q_ff    [0:QB];
   logic [DW-1:0]  dm_ff   [0:QB];
   div_ctrl_type   dc_ff   [0:QB];
   logic           dv_ff   [0:QB];

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff[0] <= DW'(n6_ff >> (FRAC + 1));
         nlo_ff[0] <= {n6_ff[FRAC:0], {FRAC{1'b0}}};
         q_ff[0]   <= '0;
         dm_ff[0]  <= m6_ff;
         dc_ff[0]  <= '{hit: hit6_ff, tneg: tneg6_ff,
                        ovf: {{(FRAC+1){1'b0}}, n6_ff} >= {m6_ff, {(FRAC+1){1'b0}}}};
      end
   end

   for (genvar j = 0; j < QB; j++) begin : g_div
      logic [DW:0] rs;
      logic        ge;
      assign rs = {rem_ff[j], nlo_ff[j][QB-1]};
      assign ge = rs >= {1'b0, dm_ff[j]};
      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[j+1] <= ge ? DW'(rs - {1'b0, dm_ff[j]}) : DW'(rs);
            nlo_ff[j+1] <= nlo_ff[j] << 1;
            q_ff[j+1]   <= {q_ff[j][QB-2:0], ge};
            dm_ff[j+1]  <= dm_ff[j];
            dc_ff[j+1]  <= dc_ff[j];
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[j+1] <= 1'b0;
         end else if (adv) begin
            dv_ff[j+1] <= dv_ff[j];
         end
      end
   end

   // saturation and output word
   logic [QB-1:0]  qf;
   div_ctrl_type   cf;
   logic [31:0]    dist_in;
   logic           hit_ff;
   logic [31:0]    dist_ff;

   assign qf = q_ff[QB];
   assign cf = dc_ff[QB];

   always_comb begin
      if (!cf.hit) begin
         dist_in = '0;
      end else if (cf.tneg) begin
         if (cf.ovf || qf > QB'(33'h0_8000_0000)) dist_in = 32'h8000_0000;
         else dist_in = 32'd0 - qf[31:0];
      end else begin
         if (cf.ovf || qf[QB-1:31] != '0) dist_in = 32'h7FFF_FFFF;
         else dist_in = qf[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         hit_ff  <= cf.hit;
         dist_ff <= dist_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         v3_ff    <= 1'b0;
         v4_ff    <= 1'b0;
         v5_ff    <= 1'b0;
         v6_ff    <= 1'b0;
         dv_ff[0] <= 1'b0;
         out_v_ff <= 1'b0;
      end else if (adv) begin
         v1_ff    <= req_tvalid;
         v2_ff    <= v1_ff;
         v3_ff    <= v2_ff;
         v4_ff    <= v3_ff;
         v5_ff    <= v4_ff;
         v6_ff    <= v5_ff;
         dv_ff[0] <= v6_ff;
         out_v_ff <= dv_ff[QB];
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = {7'd0, dist_ff, hit_ff};

   // checks
   a_nohit_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata[32:1] == '0)
      else $error("miss with nonzero distance");

   a_den_zero_miss: assert property (@(posedge clock) disable iff (reset)
      v5_ff && det_ff[0] == '0 && adv |=> !hit6_ff)
      else $error("hit on zero denominator");

   a_stall_ready: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("input taken while pipeline held");

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      dv_ff[QB] && !dc_ff[QB].ovf |-> rem_ff[QB] < dm_ff[QB])
      else $error("divider remainder out of range");

endmodule
`default_nettype wire

FILE: tb/tb_ray_triangle_intersect.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ray_triangle_intersect
// Streams rays against triangles written over the csr port and checks every
// hit flag and Q16.16 distance against an exact 128-bit Cramer's rule
// predictor. Covers the reset (all-zero) triangle, directed corner, edge,
// parallel, negative and saturating cases, then aimed and random rays over
// several triangles, with random idling on both stream sides but in the last run.
// ----------------------------------------------------------------------------
module tb_ray_triangle_intersect;
   import rti_pkg::*;

   typedef logic signed [127:0] wide_type;
   typedef struct packed {
      logic        hit;
      logic [31:0] distance;
   } isect_type;

   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 60;

   logic          clock;
   logic          reset;
   logic [119:0]  req_tdata;
   logic          req_tvalid;
   logic          req_tready;
   logic [39:0]   rsp_tdata;
   logic          rsp_tvalid;
   logic          rsp_tready;
   logic          csr_psel;
   logic          csr_penable;
   logic          csr_pwrite;
   logic [AW-1:0] csr_paddr;
   logic [63:0]   csr_pwdata;
   logic [63:0]   csr_prdata;
   logic          csr_pready;

   logic [59:0]   vert_q [3];
   isect_type     pending_hits [$];
   int            mismatch_count;
   int            cycle_count;
   int            stall_left;
   bit            steady_run;

   ray_triangle_intersect i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic wide_type field_val(input logic [19:0] f);
      return wide_type'(signed'(f));
   endfunction

   function automatic longint coord(input logic [59:0] w, input int axis);
      return longint'(signed'(w[axis*20 +: 20]));
   endfunction

   function automatic wide_type det3(input wide_type p [3], input wide_type q [3],
                                     input wide_type r [3]);
      wide_type m0, m1, m2;
      m0 = q[1] * r[2] - r[1] * q[2];
      m1 = p[1] * r[2] - r[1] * p[2];
      m2 = p[1] * q[2] - q[1] * p[2];
      return p[0] * m0 - q[0] * m1 + r[0] * m2;
   endfunction

   function automatic isect_type intersect_predict(input logic [119:0] ray);
      wide_type e1 [3], e2 [3], s [3], d [3];
      wide_type den, db, dg, dt, diff;
      logic [127:0] num, mag, quo;
      logic dneg, tneg, bok, gok, sok;
      isect_type res;
      res = '0;
      for (int a = 0; a < 3; a++) begin
         e1[a] = wide_type'(coord(vert_q[0], a)) - wide_type'(coord(vert_q[1], a));
         e2[a] = wide_type'(coord(vert_q[0], a)) - wide_type'(coord(vert_q[2], a));
         s[a]  = wide_type'(coord(vert_q[0], a)) - field_val(ray[a*20 +: 20]);
         d[a]  = field_val(ray[(a+3)*20 +: 20]);
      end
      den = det3(e1, e2, d);
      if (den == 0) return res;
      db = det3(s, e2, d);
      dg = det3(e1, s, d);
      dt = det3(e1, e2, s);
      dneg = den < 0;
      bok = (db == 0) || ((db < 0) == dneg);
      gok = (dg == 0) || ((dg < 0) == dneg);
      diff = db + dg - den;
      sok = dneg ? (diff >= 0) : (diff <= 0);
      if (!(bok && gok && sok)) return res;
      tneg = (dt < 0) != dneg;
      num = (dt < 0) ? -dt : dt;
      num = num << FRAC;
      mag = dneg ? -den : den;
      quo = num / mag;
      res.hit = 1'b1;
      if (tneg)
         res.distance = (quo > 128'h8000_0000) ? 32'h8000_0000 : 32'(-quo);
      else
         res.distance = (quo > 128'h7FFF_FFFF) ? 32'h7FFF_FFFF : quo[31:0];
      return res;
   endfunction

   function automatic logic [119:0] pack_ray(input longint o [3], input longint d [3]);
      logic [119:0] w;
      for (int a = 0; a < 3; a++) begin
         w[a*20 +: 20]     = o[a][19:0];
         w[(a+3)*20 +: 20] = d[a][19:0];
      end
      return w;
   endfunction

   function automatic logic [63:0] pack_vertex(input longint x, input longint y, input longint z);
      return {4'h0, z[19:0], y[19:0], x[19:0]};
   endfunction

   task automatic send_ray(input logic [119:0] ray);
      if (!steady_run && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_tdata  <= ray;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      pending_hits.insert(pending_hits.size(), intersect_predict(ray));
   endtask

   task automatic send_xyz(input longint ox, input longint oy, input longint oz,
                           input longint dx, input longint dy, input longint dz);
      longint o [3], d [3];
      o = '{ox, oy, oz};
      d = '{dx, dy, dz};
      send_ray(pack_ray(o, d));
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_hits.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input reg_index_type idx, input logic [63:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 3'b000};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      vert_q[idx] = value[59:0];
   endtask

   task automatic set_triangle(input logic [63:0] a, input logic [63:0] b, input logic [63:0] c);
      wait_idle();
      csr_write(REG_VERTEX_A, a);
      csr_write(REG_VERTEX_B, b);
      csr_write(REG_VERTEX_C, c);
   endtask

   // ray aimed through a random point of the triangle, with direction components sometimes negated
   task automatic send_aimed();
      longint o [3], d [3], p [3];
      longint vmax;
      int u, v, sh;
      u = $urandom_range(0, 256);
      v = $urandom_range(0, 256 - u);
      sh = $urandom_range(0, 10);
      for (int a = 0; a < 3; a++) begin
         p[a] = coord(vert_q[0], a)
              + ((coord(vert_q[1], a) - coord(vert_q[0], a)) * u
              +  (coord(vert_q[2], a) - coord(vert_q[0], a)) * v) / 256;
         o[a] = (longint'($urandom_range(0, 1048575)) - 524288) >>> sh;
         d[a] = p[a] - o[a];
      end
      vmax = 0;
      for (int a = 0; a < 3; a++) begin
         if (d[a] > vmax) vmax = d[a];
         if (-d[a] > vmax) vmax = -d[a];
      end
      sh = $urandom_range(0, 3);
      while ((vmax >>> sh) > 524287) sh++;
      for (int a = 0; a < 3; a++) begin
         d[a] = d[a] >>> sh;
         if ($urandom_range(0, 5) == 0) d[a] = -d[a];
      end
      send_ray(pack_ray(o, d));
   endtask

   task automatic send_noise();
      logic [119:0] w;
      for (int k = 0; k < 4; k++) w[k*30 +: 30] = 30'($urandom());
      send_ray(w);
   endtask

   function automatic logic [63:0] random_vertex(input int sh);
      logic [63:0] w;
      w = {$urandom(), $urandom()};
      for (int a = 0; a < 3; a++)
         w[a*20 +: 20] = 20'(longint'(signed'(w[a*20 +: 20])) >>> sh);
      return w;
   endfunction

   task automatic test_reset_triangle();
      send_xyz(0, 0, 0, 0, 0, 0);
      send_xyz(1024, 1024, -4096, 0, 0, 4096);
      repeat (3) send_noise();
   endtask

   task automatic test_directed();
      set_triangle(pack_vertex(0, 0, 0), pack_vertex(4096, 0, 0), pack_vertex(0, 4096, 0));
      send_xyz(1024, 1024, -4096, 0, 0, 4096);
      send_xyz(0, 0, -4096, 0, 0, 4096);
      send_xyz(4096, 0, -4096, 0, 0, 4096);
      send_xyz(0, 4096, -4096, 0, 0, 4096);
      send_xyz(2048, 2048, -4096, 0, 0, 4096);
      send_xyz(2049, 2048, -4096, 0, 0, 4096);
      send_xyz(-1, 0, -4096, 0, 0, 4096);
      send_xyz(0, -1, -4096, 0, 0, 4096);
      send_xyz(1024, 1024, -4096, 4096, 0, 0);
      send_xyz(1024, 1024, -4096, 0, 0, 0);
      send_xyz(1024, 1024, 4096, 0, 0, 4096);
      send_xyz(1024, 1024, 4096, 0, 0, -4096);
      send_xyz(100, 100, -524288, 0, 0, 1);
      send_xyz(100, 100, 524287, 0, 0, 1);
      send_xyz(100, 100, -3, 0, 0, 7);
      send_xyz(100, 100, 5, 0, 0, -3);
      send_xyz(-524288, -524288, -524288, 524287, 524287, 524287);
      send_xyz(524287, 524287, 524287, -524288, -524288, -524288);
      send_xyz(1000, 500, -4096, 200, 100, 4096);
   endtask

   task automatic test_extreme_triangle();
      set_triangle(pack_vertex(524287, 524287, 524287), pack_vertex(-524288, 524287, -524288),
                   pack_vertex(-524288, -524288, 524287) | 64'hF000_0000_0000_0000);
      repeat (8) send_aimed();
      repeat (4) send_noise();
      set_triangle(pack_vertex(-524288, -524288, 0), pack_vertex(524287, -524288, 0),
                   pack_vertex(0, 524287, 0));
      send_xyz(0, 0, -524288, 0, 0, 524287);
      send_xyz(0, 0, 524287, 0, 0, -1);
      repeat (8) send_aimed();
   endtask

   task automatic test_random_rays(input int n_items, input int sh);
      set_triangle(random_vertex(sh), random_vertex(sh), random_vertex(sh));
      for (int i = 0; i < n_items; i++) begin
         if ($urandom_range(0, 4) == 0) send_noise();
         else send_aimed();
      end
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   always @(posedge clock) begin
      isect_type got, want;
      logic ready_next;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.hit      = rsp_tdata[0];
         got.distance = rsp_tdata[32:1];
         if (pending_hits.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected word: hit %0b distance %h", got.hit, got.distance);
         end else begin
            want = pending_hits.pop_front();
            if (got.hit !== want.hit || got.distance !== want.distance) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: hit exp %0b got %0b, distance exp %h got %h",
                           want.hit, got.hit, want.distance, got.distance);
            end
         end
      end
      if (stall_left > 0) begin
         stall_left--;
         ready_next = 1'b0;
      end else if (!steady_run && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 6);
         ready_next = 1'b0;
      end else begin
         ready_next = 1'b1;
      end
      rsp_tready <= ready_next;
   end

   initial begin
      reset          = 1'b1;
      req_tdata      = '0;
      req_tvalid     = 1'b0;
      rsp_tready     = 1'b0;
      csr_psel       = 1'b0;
      csr_penable    = 1'b0;
      csr_pwrite     = 1'b0;
      csr_paddr      = '0;
      csr_pwdata     = '0;
      mismatch_count = 0;
      cycle_count    = 0;
      stall_left     = 0;
      steady_run     = 1'b0;
      for (int k = 0; k < 3; k++) vert_q[k] = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_triangle();
      test_directed();
      test_extreme_triangle();
      test_random_rays(80, 0);
      test_random_rays(80, 4);
      test_random_rays(70, 10);
      test_random_rays(70, 15);
      test_random_rays(60, 2);
      steady_run = 1'b1;
      test_random_rays(60, 6);
      wait_idle();
      if (mismatch_count == 0 && pending_hits.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

FILE: sim.f
rtl/rti_pkg.sv
rtl/ray_triangle_intersect.sv
tb/tb_ray_triangle_intersect.sv
